// ===== rtl/uitp_pkg.sv =====
// Shared types and constants for the unsigned integer text parser.
// No dependencies; every other file of the block imports this package.
package uitp_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int COUNT_BITS  = 16;
  localparam int BASE_BITS   = 6;
  localparam int CHAR_BITS   = 8;
  localparam int OUT_VALUE_W = 64;
  localparam int OUT_COUNT_W = 16;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
  localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_MAX  = BASE_BITS'(36);

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                 is_blank;
    logic                 is_zero;
    logic                 is_x;
    logic                 is_alnum;
    logic [BASE_BITS-1:0] digit;
  } char_class_t;

  typedef struct packed {
    phase_t                phase;
    logic [BASE_BITS-1:0]  base;
    logic [VALUE_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] count;
  } parse_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] consumed;
    logic [BASE_BITS-1:0]  base_used;
  } result_t;

endpackage

// ===== rtl/uitp_char_decode.sv =====
// Character classifier: whitespace, prefix characters and digit value.
// Depends on uitp_pkg.
module uitp_char_decode
  import uitp_pkg::*;
(
  input  logic [CHAR_BITS-1:0] char_code,
  output char_class_t          cls
);

  logic is_num;
  logic is_lower;
  logic is_upper;
  logic [CHAR_BITS-1:0] d;

  always_comb begin
    is_num   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_lower = (char_code >= CH_LA) && (char_code <= CH_LZ);
    is_upper = (char_code >= CH_UA) && (char_code <= CH_UZ);
    if (is_num) begin
      d = char_code - CH_ZERO;
    end else if (is_lower) begin
      d = char_code - CH_LA + CHAR_BITS'(10);
    end else begin
      d = char_code - CH_UA + CHAR_BITS'(10);
    end
    cls.is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
    cls.is_zero  = (char_code == CH_ZERO);
    cls.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
    cls.is_alnum = is_num || is_lower || is_upper;
    cls.digit    = d[BASE_BITS-1:0];
  end

endmodule

// ===== rtl/uitp_parse_core.sv =====
// Parse state register and the per-character update, including the
// multiply-accumulate. Depends on uitp_pkg.
module uitp_parse_core
  import uitp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 last,
  input  char_class_t          cls,
  input  logic [BASE_BITS-1:0] radix,
  output result_t              res
);

  parse_state_t st;
  parse_state_t st_next;
  logic [BASE_BITS-1:0] radix_sat;
  logic [BASE_BITS-1:0] take_base;
  logic take;
  logic bump;
  logic digit_ok;
  logic [VALUE_BITS+BASE_BITS-1:0] prod;
  logic [VALUE_BITS-1:0] acc_mac;

  assign radix_sat = (radix > BASE_MAX) ? BASE_MAX : radix;
  assign digit_ok  = cls.is_alnum && (cls.digit < take_base);
  assign prod      = st.acc * take_base;
  assign acc_mac   = prod[VALUE_BITS-1:0] + VALUE_BITS'(cls.digit);

  always_comb begin
    st_next   = st;
    take      = 1'b0;
    bump      = 1'b0;
    take_base = st.base;
    unique case (st.phase)
      PH_SKIP: begin
        if (cls.is_blank) begin
          bump = 1'b1;
        end else if (radix_sat == BASE_AUTO) begin
          if (cls.is_zero) begin
            bump          = 1'b1;
            st_next.base  = BASE_OCT;
            st_next.phase = PH_ZERO;
          end else begin
            st_next.base = BASE_DEC;
            take_base    = BASE_DEC;
            take         = 1'b1;
          end
        end else begin
          st_next.base = radix_sat;
          take_base    = radix_sat;
          take         = 1'b1;
        end
      end
      PH_ZERO: begin
        if (cls.is_x) begin
          bump          = 1'b1;
          st_next.base  = BASE_HEX;
          st_next.phase = PH_DIGITS;
        end else begin
          st_next.base = BASE_OCT;
          take_base    = BASE_OCT;
          take         = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      PH_STOP:   take = 1'b0;
      default:   take = 1'b0;
    endcase
    if (take) begin
      if (digit_ok) begin
        st_next.acc   = acc_mac;
        st_next.phase = PH_DIGITS;
        bump          = 1'b1;
      end else begin
        st_next.phase = PH_STOP;
      end
    end
    if (bump && (st.count != '1)) begin
      st_next.count = st.count + COUNT_BITS'(1);
    end
    // A string of whitespace alone reports the base it would have used.
    res.value     = st_next.acc;
    res.consumed  = st_next.count;
    res.base_used = st_next.base;
    if (st_next.phase == PH_SKIP) begin
      res.base_used = (radix_sat == BASE_AUTO) ? BASE_DEC : radix_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_SKIP;
      st.base  <= '0;
      st.acc   <= '0;
      st.count <= '0;
    end else if (advance) begin
      if (last) begin
        st.phase <= PH_SKIP;
        st.base  <= '0;
        st.acc   <= '0;
        st.count <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> (st.phase == PH_SKIP) && (st.acc == '0) && (st.count == '0))
    else $error("parse state not cleared after final character");

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    advance && !last && (st.phase == PH_STOP) |=> (st.phase == PH_STOP))
    else $error("stopped parse resumed within a string");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    advance && !last |=> st.count >= $past(st.count))
    else $error("consumed count went down within a string");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st.acc) && $stable(st.count) && $stable(st.phase))
    else $error("parse state changed without a character");

endmodule

// ===== rtl/unsigned_integer_text_parser.sv =====
// Top level of the unsigned integer text parser: input register, config
// register, output register. Depends on uitp_pkg, uitp_char_decode, uitp_parse_core.
//
//   Channel   Dir   Payload                                  Request when
//   s_*       in    tdata[7:0] char_code, tlast last_char    s_tvalid & s_tready
//   m_*       out   tdata value|consumed, tuser base_used    m_tvalid & m_tready
//   cfg_*     in    cfg_data[5:0] radix                      cfg_valid & cfg_ready
//
// One character request is taken per clock unless the input side is backed
// up. A character is first held in the input register; then the decode and
// multiply-accumulate update the parse state, and the result of a final
// character is loaded into the output register with that update. The 64 by
// 6 multiply-accumulate in the parse state loop sets the clock. Reset clears
// the parse state, the radix (automatic mode) and both valid flags. Characters
// that are not final keep flowing while a result waits; only a final character
// waits for the output register to free up, which then backs up the input side.
module unsigned_integer_text_parser
  import uitp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] value, [79:64] consumed
  output logic [7:0]  m_tuser,   // [5:0] base_used, upper bits zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data   // radix, 0 selects automatic detection
);

  // Input register stage.
  logic                 in_valid;
  logic [CHAR_BITS-1:0] in_char;
  logic                 in_last;

  // Configured radix.
  logic [BASE_BITS-1:0] radix;

  // Output register stage.
  logic    out_valid;
  result_t out_res;

  char_class_t cls;
  result_t     res;
  logic        advance;

  // A final character may only move on when the output register can take it.
  assign advance   = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  uitp_char_decode u_decode (
    .char_code (in_char),
    .cls       (cls)
  );

  uitp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .last    (in_last),
    .cls     (cls),
    .radix   (radix),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {OUT_COUNT_W'(out_res.consumed), OUT_VALUE_W'(out_res.value)};
  assign m_tuser  = {2'b00, out_res.base_used};

endmodule
